// ===== hdl/operating_point_selector_assert.svh =====
// Assertion macros for the operating point selector.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef OPERATING_POINT_SELECTOR_ASSERT_SVH
`define OPERATING_POINT_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, skipped while reset is applied.
`define OPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked property that must also hold during reset.
`define OPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OPS_ASSERT(lbl, prop, msg)
`define OPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/ops_pkg.sv =====
`default_nettype none

package ops_pkg;

	// Field widths.
	localparam int KhzW  = 22;
	localparam int BusW  = 8;
	localparam int IdxW  = 5;
	localparam int VerW  = 2;
	localparam int ProdW = 16;
	localparam int CfgIdxW = 3;

	localparam logic [KhzW-1:0] KhzMask = {KhzW{1'b1}};

	// Ratio ROM depth and candidate lanes: three bus slots per ROM entry.
	localparam int RatioEntries = 32;
	localparam int NumSlots = 3;
	localparam int NumLanes = NumSlots * RatioEntries;

	// Sizes of the 4:1 reduction tree levels.
	localparam int TreeN1 = (NumLanes + 3) / 4;
	localparam int TreeN2 = (TreeN1 + 3) / 4;
	localparam int TreeN3 = (TreeN2 + 3) / 4;

	// Bus speeds in MHz of the scaled slots.
	localparam logic [BusW-1:0] BusSlow = 8'd66;
	localparam logic [BusW-1:0] BusMid  = 8'd100;
	localparam logic [BusW-1:0] BusFast = 8'd133;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		CfgChipVersion = 3'd0,
		CfgBusScaling  = 3'd1,
		CfgFixedBus    = 3'd2,
		CfgLowestKhz   = 3'd3,
		CfgHighestKhz  = 3'd4
	} cfg_reg_t;

	// Multiplier times ten by chip version; zero marks a reserved entry.
	localparam logic [7:0] RatioRom [4][32] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 30, 40, 0, 0, 35, 45, 55, 60, 70, 80, 50, 65, 75, 0, 0,
		  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{100, 30, 40, 90, 95, 35, 45, 55, 60, 70, 80, 50, 65, 75, 85, 120,
		  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{100, 30, 40, 90, 95, 35, 45, 55, 60, 70, 80, 50, 65, 75, 85, 120,
		  0, 110, 120, 0, 105, 115, 125, 135, 140, 150, 160, 130, 145, 155, 0, 0}
	};

	// One candidate operating point as it travels through the tree.
	typedef struct packed {
		logic            ok;
		logic [KhzW-1:0] khz;
		logic [1:0]      rank;
		logic [IdxW-1:0] idx;
		logic [BusW-1:0] bus;
	} cand_t;

	localparam cand_t CandNone = '0;

	// Bus speed of a slot; slot 0 carries the fixed bus when scaling is off.
	function automatic logic [BusW-1:0] slot_bus(input logic [1:0] slot,
			input logic scaling, input logic [BusW-1:0] fixed_bus);
		logic [BusW-1:0] r;
		case (slot)
			2'd0:    r = scaling ? BusSlow : fixed_bus;
			2'd1:    r = BusMid;
			default: r = BusFast;
		endcase
		return r;
	endfunction

	// Pick the better of two candidates. Equal frequencies go to the one
	// earlier in search order.
	function automatic cand_t cand_pick(input cand_t a, input cand_t b,
			input logic hi_wins);
		cand_t r;
		logic a_first;
		a_first = ({a.rank, a.idx} <= {b.rank, b.idx});
		if (!a.ok) begin
			r = b;
		end else if (!b.ok) begin
			r = a;
		end else if (a.khz == b.khz) begin
			r = a_first ? a : b;
		end else if ((a.khz > b.khz) == hi_wins) begin
			r = a;
		end else begin
			r = b;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/operating_point_selector.sv =====
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------
// in       | input     | in_valid, in_stall  | policy_min_khz, policy_max_khz,
//          |           |                     | favour_performance
// out      | output    | out_valid, out_stall| point_found, ratio_index, bus_mhz,
//          |           |                     | point_khz, adjusted_min/max_khz
// cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// The pipeline has seven register stages: clamp and lane products, lane
// frequencies, range flags, three 4:1 levels of the candidate tree and the
// output register. One item can enter every cycle unless in_stall is high.
// Reset clears all stage valid bits and loads the register reset values.
// A stall on the output holds the last stage; empty stages upstream keep
// filling until the pipeline is full.
`default_nettype none
module operating_point_selector (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ops_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [ops_pkg::KhzW-1:0]      cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ops_pkg::KhzW-1:0]      policy_min_khz,
	input  wire logic [ops_pkg::KhzW-1:0]      policy_max_khz,
	input  wire logic                          favour_performance,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               point_found,
	output logic [ops_pkg::IdxW-1:0]           ratio_index,
	output logic [ops_pkg::BusW-1:0]           bus_mhz,
	output logic [ops_pkg::KhzW-1:0]           point_khz,
	output logic [ops_pkg::KhzW-1:0]           adjusted_min_khz,
	output logic [ops_pkg::KhzW-1:0]           adjusted_max_khz
);
	import ops_pkg::*;
	`include "operating_point_selector_assert.svh"

	// Configuration registers.
	logic [VerW-1:0] chip_version_q;
	logic            bus_scaling_on_q;
	logic [BusW-1:0] fixed_bus_mhz_q;
	logic [KhzW-1:0] lowest_khz_q;
	logic [KhzW-1:0] highest_khz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_version_q   <= 2'd2;
			bus_scaling_on_q <= 1'b0;
			fixed_bus_mhz_q  <= 8'd100;
			lowest_khz_q     <= '0;
			highest_khz_q    <= 22'd2128000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgChipVersion: chip_version_q   <= cfg_data[VerW-1:0];
				CfgBusScaling:  bus_scaling_on_q <= cfg_data[0];
				CfgFixedBus:    fixed_bus_mhz_q  <= cfg_data[BusW-1:0];
				CfgLowestKhz:   lowest_khz_q     <= cfg_data;
				CfgHighestKhz:  highest_khz_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage valid bits and the stall chain: a stage moves when it is empty
	// or the stage after it moves.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || !out_stall;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// Stage 1: clamp the policy to the chip limits, form lane products.
	logic [KhzW-1:0] mn_c, mx_c;

	always_comb begin
		mn_c = policy_min_khz;
		mx_c = policy_max_khz;
		if (mn_c < lowest_khz_q) mn_c = lowest_khz_q;
		if (mx_c < lowest_khz_q) mx_c = lowest_khz_q;
		if (mn_c > highest_khz_q) mn_c = highest_khz_q;
		if (mx_c > highest_khz_q) mx_c = highest_khz_q;
		if (mn_c > mx_c) mn_c = mx_c;
	end

	logic [ProdW-1:0] prod_c [NumLanes];
	logic             ok_c [NumLanes];

	ops_prod u_prod (
		.chip_version   (chip_version_q),
		.bus_scaling_on (bus_scaling_on_q),
		.fixed_bus_mhz  (fixed_bus_mhz_q),
		.prod           (prod_c),
		.ok             (ok_c)
	);

	logic [KhzW-1:0]  mn_s1, mx_s1, mn_s2, mx_s2, mn_s3, mx_s3;
	logic [KhzW-1:0]  mn_s4, mx_s4, mn_s5, mx_s5, mn_s6, mx_s6;
	logic             perf_s1, perf_s2, perf_s3, perf_s4, perf_s5, perf_s6;
	logic [ProdW-1:0] prod_s1 [NumLanes];
	logic             ok_s1 [NumLanes];
	logic             ok_s2 [NumLanes];
	logic [KhzW-1:0]  khz_s2 [NumLanes];
	cand_t            a_s3 [NumLanes];
	cand_t            b_s3 [NumLanes];
	cand_t            a_s4 [TreeN1];
	cand_t            b_s4 [TreeN1];
	cand_t            a_s5 [TreeN2];
	cand_t            b_s5 [TreeN2];
	cand_t            a_s6 [TreeN3];
	cand_t            b_s6 [TreeN3];

	// Request fields travel alongside the lanes.
	always_ff @(posedge clk) begin
		if (en1) begin
			mn_s1   <= mn_c;
			mx_s1   <= mx_c;
			perf_s1 <= favour_performance;
		end
		if (en2) begin
			mn_s2   <= mn_s1;
			mx_s2   <= mx_s1;
			perf_s2 <= perf_s1;
		end
		if (en3) begin
			mn_s3   <= mn_s2;
			mx_s3   <= mx_s2;
			perf_s3 <= perf_s2;
		end
		if (en4) begin
			mn_s4   <= mn_s3;
			mx_s4   <= mx_s3;
			perf_s4 <= perf_s3;
		end
		if (en5) begin
			mn_s5   <= mn_s4;
			mx_s5   <= mx_s4;
			perf_s5 <= perf_s4;
		end
		if (en6) begin
			mn_s6   <= mn_s5;
			mx_s6   <= mx_s5;
			perf_s6 <= perf_s5;
		end
	end

	// Stages 1 to 3 per lane: product, frequency in kHz, then range flags.
	// Set A holds lanes inside the bounds; set B lanes above the maximum.
	for (genvar p = 0; p < NumSlots; p++) begin : g_slot
		for (genvar i = 0; i < RatioEntries; i++) begin : g_ent
			localparam int N = p * RatioEntries + i;
			logic [KhzW:0]   khz_full;
			logic [1:0]      rank;
			logic [BusW-1:0] bus;
			logic            in_rng;
			logic            above;
			cand_t           cand_a;
			cand_t           cand_b;

			assign khz_full = (KhzW+1)'(prod_s1[N]) * (KhzW+1)'(100);
			assign rank = (bus_scaling_on_q && perf_s2) ? 2'(NumSlots - 1 - p) : 2'(p);
			assign bus = slot_bus(2'(p), bus_scaling_on_q, fixed_bus_mhz_q);
			assign in_rng = ok_s2[N] && (khz_s2[N] >= mn_s2) && (khz_s2[N] <= mx_s2);
			assign above = ok_s2[N] && (khz_s2[N] > mx_s2);
			assign cand_a = '{ok: in_rng, khz: khz_s2[N], rank: rank, idx: IdxW'(i),
				bus: bus};
			assign cand_b = '{ok: above, khz: khz_s2[N], rank: rank, idx: IdxW'(i),
				bus: bus};

			always_ff @(posedge clk) begin
				if (en1) begin
					prod_s1[N] <= prod_c[N];
					ok_s1[N]   <= ok_c[N];
				end
				if (en2) begin
					khz_s2[N] <= khz_full[KhzW-1:0];
					ok_s2[N]  <= ok_s1[N];
				end
				if (en3) begin
					a_s3[N] <= cand_a;
					b_s3[N] <= cand_b;
				end
			end
		end
	end

	// Stage 4: first tree level, four lanes to one.
	for (genvar g = 0; g < TreeN1; g++) begin : g_t1
		cand_t ga [4];
		cand_t gb [4];
		for (genvar k = 0; k < 4; k++) begin : g_in
			if (g * 4 + k < NumLanes) begin : g_used
				assign ga[k] = a_s3[g*4+k];
				assign gb[k] = b_s3[g*4+k];
			end else begin : g_pad
				assign ga[k] = CandNone;
				assign gb[k] = CandNone;
			end
		end
		always_ff @(posedge clk) begin
			if (en4) begin
				a_s4[g] <= cand_pick(cand_pick(ga[0], ga[1], perf_s3),
					cand_pick(ga[2], ga[3], perf_s3), perf_s3);
				b_s4[g] <= cand_pick(cand_pick(gb[0], gb[1], 1'b0),
					cand_pick(gb[2], gb[3], 1'b0), 1'b0);
			end
		end
	end

	// Stage 5: second tree level.
	for (genvar g = 0; g < TreeN2; g++) begin : g_t2
		cand_t ga [4];
		cand_t gb [4];
		for (genvar k = 0; k < 4; k++) begin : g_in
			if (g * 4 + k < TreeN1) begin : g_used
				assign ga[k] = a_s4[g*4+k];
				assign gb[k] = b_s4[g*4+k];
			end else begin : g_pad
				assign ga[k] = CandNone;
				assign gb[k] = CandNone;
			end
		end
		always_ff @(posedge clk) begin
			if (en5) begin
				a_s5[g] <= cand_pick(cand_pick(ga[0], ga[1], perf_s4),
					cand_pick(ga[2], ga[3], perf_s4), perf_s4);
				b_s5[g] <= cand_pick(cand_pick(gb[0], gb[1], 1'b0),
					cand_pick(gb[2], gb[3], 1'b0), 1'b0);
			end
		end
	end

	// Stage 6: third tree level.
	for (genvar g = 0; g < TreeN3; g++) begin : g_t3
		cand_t ga [4];
		cand_t gb [4];
		for (genvar k = 0; k < 4; k++) begin : g_in
			if (g * 4 + k < TreeN2) begin : g_used
				assign ga[k] = a_s5[g*4+k];
				assign gb[k] = b_s5[g*4+k];
			end else begin : g_pad
				assign ga[k] = CandNone;
				assign gb[k] = CandNone;
			end
		end
		always_ff @(posedge clk) begin
			if (en6) begin
				a_s6[g] <= cand_pick(cand_pick(ga[0], ga[1], perf_s5),
					cand_pick(ga[2], ga[3], perf_s5), perf_s5);
				b_s6[g] <= cand_pick(cand_pick(gb[0], gb[1], 1'b0),
					cand_pick(gb[2], gb[3], 1'b0), 1'b0);
			end
		end
	end

	// Final pick over what is left of the tree.
	cand_t a_fin, b_fin;

	if (TreeN3 > 1) begin : g_fin2
		assign a_fin = cand_pick(a_s6[0], a_s6[1], perf_s6);
		assign b_fin = cand_pick(b_s6[0], b_s6[1], 1'b0);
	end else begin : g_fin1
		assign a_fin = a_s6[0];
		assign b_fin = b_s6[0];
	end

	// Stage 7: output register. With nothing inside the bounds the maximum
	// is raised to the lowest point above it; the points at that frequency
	// are then the only ones inside, and the first in search order wins.
	logic            found_s7;
	logic [IdxW-1:0] idx_s7;
	logic [BusW-1:0] bus_s7;
	logic [KhzW-1:0] khz_s7, mn_s7, mx_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			mn_s7 <= mn_s6;
			if (a_fin.ok) begin
				found_s7 <= 1'b1;
				idx_s7   <= a_fin.idx;
				bus_s7   <= a_fin.bus;
				khz_s7   <= a_fin.khz;
				mx_s7    <= mx_s6;
			end else if (b_fin.ok) begin
				found_s7 <= 1'b1;
				idx_s7   <= b_fin.idx;
				bus_s7   <= b_fin.bus;
				khz_s7   <= b_fin.khz;
				mx_s7    <= b_fin.khz;
			end else begin
				found_s7 <= 1'b0;
				idx_s7   <= '0;
				bus_s7   <= '0;
				khz_s7   <= '0;
				mx_s7    <= KhzMask;
			end
		end
	end

	assign out_valid        = v_s7;
	assign point_found      = found_s7;
	assign ratio_index      = idx_s7;
	assign bus_mhz          = bus_s7;
	assign point_khz        = khz_s7;
	assign adjusted_min_khz = mn_s7;
	assign adjusted_max_khz = mx_s7;

	// A found point lies inside the reported bounds.
	`OPS_ASSERT(a_point_in_bounds, out_valid && point_found |-> (point_khz >= adjusted_min_khz) && (point_khz <= adjusted_max_khz), "chosen point outside the adjusted bounds")
	// Without a point the maximum has been raised to all ones.
	`OPS_ASSERT(a_none_max_ones, out_valid && !point_found |-> (adjusted_max_khz == KhzMask) && (point_khz == '0), "no point found but maximum not raised to all ones")
	// The adjusted bounds are ordered.
	`OPS_ASSERT(a_bounds_ordered, out_valid |-> adjusted_min_khz <= adjusted_max_khz, "adjusted minimum above adjusted maximum")
	// The input stalls only when every stage holds an item.
	`OPS_ASSERT_ALWAYS(a_stall_full, in_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7, "input stalled while the pipeline has room")

endmodule
`default_nettype wire

// ===== hdl/ops_prod.sv =====
`default_nettype none

module ops_prod (
	input  wire logic [ops_pkg::VerW-1:0]  chip_version,
	input  wire logic                      bus_scaling_on,
	input  wire logic [ops_pkg::BusW-1:0]  fixed_bus_mhz,
	output logic [ops_pkg::ProdW-1:0]      prod [ops_pkg::NumLanes],
	output logic                           ok [ops_pkg::NumLanes]
);
	import ops_pkg::*;

	// One lane per bus slot and ROM entry: multiplier times bus speed.
	for (genvar p = 0; p < NumSlots; p++) begin : g_slot
		for (genvar i = 0; i < RatioEntries; i++) begin : g_ent
			logic [7:0]      ratio;
			logic [BusW-1:0] bus;
			logic            bus_ok;
			assign ratio = RatioRom[chip_version][i];
			assign bus = slot_bus(2'(p), bus_scaling_on, fixed_bus_mhz);
			assign bus_ok = (p == 0) ? (bus_scaling_on || (fixed_bus_mhz != '0))
				: bus_scaling_on;
			assign prod[p*RatioEntries+i] = ProdW'(ratio) * ProdW'(bus);
			assign ok[p*RatioEntries+i] = (ratio != 8'd0) && bus_ok;
		end
	end

endmodule

`default_nettype wire
